@@ rtl/evm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evm_pkg: shared constants and types for the view matrix block
// CORDIC constants, the arctangent table and the cell payload type.
// ----------------------------------------------------------------------------
package evm_pkg;
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int STEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int AW = $clog2(ATAN_ENTRIES);
	localparam int CW = 34;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

	function automatic logic signed [CW-1:0] atan_at(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000;  1: t = 32'h12E4051E;  2: t = 32'h09FB385B;
			3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
			9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			default: t = 32'h0;
		endcase
		return $signed({2'b00, t});
	endfunction

	// one angle in flight through a CORDIC cell
	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 flip;
	} rot_t;

	// one pose in flight: three angles and the position
	typedef struct packed {
		rot_t                 ax;
		rot_t                 ay;
		rot_t                 az;
		logic signed [31:0]   px;
		logic signed [31:0]   py;
		logic signed [31:0]   pz;
	} pose_t;
endpackage
`default_nettype wire

@@ rtl/evm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evm_cell: one CORDIC cell
// Rotates all three angles of a pose by one step and hands it on.
// ----------------------------------------------------------------------------
module evm_cell
	import evm_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] idx,
	input  wire pose_t         din,
	output pose_t              dout
);
	function automatic rot_t step(input rot_t r, input logic [AW-1:0] i);
		rot_t o;
		logic signed [CW-1:0] dx, dy, a;
		dx = r.y >>> i;
		dy = r.x >>> i;
		a  = atan_at(int'(i));
		o = r;
		if (!r.z[CW-1]) begin
			o.x = r.x - dx; o.y = r.y + dy; o.z = r.z - a;
		end else begin
			o.x = r.x + dx; o.y = r.y - dy; o.z = r.z + a;
		end
		return o;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			dout.ax <= step(din.ax, idx);
			dout.ay <= step(din.ay, idx);
			dout.az <= step(din.az, idx);
			dout.px <= din.px;
			dout.py <= din.py;
			dout.pz <= din.pz;
		end
	end
endmodule
`default_nettype wire

@@ rtl/euler_view_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_view_matrix: camera pose to 3x4 view matrix
// Pitch/yaw/roll binary angles and a Q16.16 position in, nine Q1.14
// rotation entries and a saturated Q16.16 translation row out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pose per transfer, m_axis one matrix per transfer.
//   The pose enters a chain of CORDIC cells, one cell per step (16 by
//   default); each cell rotates all three angles once and passes the pose
//   on. Behind the chain sit rounding, two product stages, matrix rounding,
//   translation products, a sum and a saturation stage.
//   Throughput: one pose per cycle while the output is not stalled;
//   the chain is one long shift pipeline.
//   Stall: the whole pipeline holds while m_axis_tvalid is high and
//   m_axis_tready low, so s_axis_tready = m_axis_tready or a free output.
//   Reset clears only the stage valid bits; payloads carry no reset.
// ----------------------------------------------------------------------------
module euler_view_matrix
	import evm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// pitch[15:0] yaw[31:16] roll[47:32] pos_x[79:48] pos_y[111:80] pos_z[143:112]
	input  wire logic [143:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// r00,r01,r02,r10,r11,r12,r20,r21,r22 (16 each, [143:0]) tx[175:144]
	// ty[207:176] tz[239:208]
	output logic [239:0]      m_axis_tdata
);
	localparam int NV = STEPS + 7;

	logic [NV-1:0] vld_q;
	logic          en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[NV-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NV-2:0], s_axis_tvalid};
		end
	end

	// angle reduction to [-quarter, +quarter)
	function automatic rot_t init(input logic [15:0] a);
		rot_t r;
		logic [15:0] b;
		r.flip = (a >= 16'h4000) && (a < 16'hC000);
		b = r.flip ? a + 16'h8000 : a;
		r.x = GAIN_Q30;
		r.y = '0;
		r.z = {{2{b[15]}}, b, 16'h0000};
		return r;
	endfunction

	pose_t chain [STEPS+1];
	always_comb begin
		chain[0].ax = init(s_axis_tdata[15:0]);
		chain[0].ay = init(s_axis_tdata[31:16]);
		chain[0].az = init(s_axis_tdata[47:32]);
		chain[0].px = $signed(s_axis_tdata[79:48]);
		chain[0].py = $signed(s_axis_tdata[111:80]);
		chain[0].pz = $signed(s_axis_tdata[143:112]);
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		evm_cell u_cell (
			.clk (clk), .en (en), .idx (AW'(g)), .din (chain[g]), .dout (chain[g+1])
		);
	end

	function automatic logic signed [15:0] rq16(input logic signed [CW-1:0] v,
			input logic flip);
		logic signed [CW-1:0] t;
		logic signed [15:0] c;
		t = (v + 34'sd32768) >>> 16;
		c = (t > 34'sd16384) ? 16'sd16384 :
			(t < -34'sd16384) ? -16'sd16384 : t[15:0];
		return flip ? -c : c;
	endfunction

	function automatic logic signed [15:0] rq42(input logic signed [47:0] v);
		logic signed [47:0] t;
		t = (v + 48'sd134217728) >>> 28;
		return (t > 48'sd16384) ? 16'sd16384 :
			(t < -48'sd16384) ? -16'sd16384 : t[15:0];
	endfunction

	function automatic logic [31:0] sat32(input logic signed [49:0] s);
		logic signed [49:0] t;
		t = (s + 50'sd8192) >>> 14;
		return (t > 50'sd2147483647) ? 32'h7FFFFFFF :
			(t < -50'sd2147483648) ? 32'h80000000 : t[31:0];
	endfunction

	// stage 1: sines and cosines
	pose_t pe;
	assign pe = chain[STEPS];
	logic signed [15:0] sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	// stage 2: two-factor products, Q.28
	logic signed [31:0] cycz_s2, sysz_s2, sycz_s2, cysz_s2, cxsy_s2, cxsz_s2,
		cxcz_s2, cycx_s2;
	logic signed [15:0] sx_s2;
	logic signed [31:0] px_s2, py_s2, pz_s2;
	// stage 3: Q.42 sums and products, m5 kept as the negated Q1.14 sine
	logic signed [47:0] m0_s3, m1_s3, m2_s3, m3_s3, m4_s3, m6_s3, m7_s3, m8_s3;
	logic signed [15:0] m5_s3;
	logic signed [31:0] px_s3, py_s3, pz_s3;
	// stage 4: rounded entries
	logic signed [15:0] m_s4 [9];
	logic signed [31:0] px_s4, py_s4, pz_s4;
	// stage 5: translation products
	logic signed [47:0] p_s5 [9];
	logic signed [15:0] m_s5 [9];
	// stage 6: sums
	logic signed [49:0] t_s6 [3];
	logic signed [15:0] m_s6 [9];
	// stage 7: output
	logic [239:0] out_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= rq16(pe.ax.y, pe.ax.flip); cx_s1 <= rq16(pe.ax.x, pe.ax.flip);
			sy_s1 <= rq16(pe.ay.y, pe.ay.flip); cy_s1 <= rq16(pe.ay.x, pe.ay.flip);
			sz_s1 <= rq16(pe.az.y, pe.az.flip); cz_s1 <= rq16(pe.az.x, pe.az.flip);
			px_s1 <= pe.px; py_s1 <= pe.py; pz_s1 <= pe.pz;

			cycz_s2 <= cy_s1 * cz_s1; sysz_s2 <= sy_s1 * sz_s1;
			sycz_s2 <= sy_s1 * cz_s1; cysz_s2 <= cy_s1 * sz_s1;
			cxsy_s2 <= cx_s1 * sy_s1; cxsz_s2 <= cx_s1 * sz_s1;
			cxcz_s2 <= cx_s1 * cz_s1; cycx_s2 <= cy_s1 * cx_s1;
			sx_s2 <= sx_s1;
			px_s2 <= px_s1; py_s2 <= py_s1; pz_s2 <= pz_s1;

			m0_s3 <= (48'(cycz_s2) <<< 14) + 48'(sysz_s2) * 48'(sx_s2);
			m1_s3 <= 48'(sycz_s2) * 48'(sx_s2) - (48'(cysz_s2) <<< 14);
			m2_s3 <= 48'(cxsy_s2) <<< 14;
			m3_s3 <= 48'(cxsz_s2) <<< 14;
			m4_s3 <= 48'(cxcz_s2) <<< 14;
			m5_s3 <= -sx_s2;
			m6_s3 <= 48'(cysz_s2) * 48'(sx_s2) - (48'(sycz_s2) <<< 14);
			m7_s3 <= 48'(cycz_s2) * 48'(sx_s2) + (48'(sysz_s2) <<< 14);
			m8_s3 <= 48'(cycx_s2) <<< 14;
			px_s3 <= px_s2; py_s3 <= py_s2; pz_s3 <= pz_s2;

			m_s4[0] <= rq42(m0_s3); m_s4[1] <= rq42(m1_s3); m_s4[2] <= rq42(m2_s3);
			m_s4[3] <= rq42(m3_s3); m_s4[4] <= rq42(m4_s3); m_s4[5] <= m5_s3;
			m_s4[6] <= rq42(m6_s3); m_s4[7] <= rq42(m7_s3); m_s4[8] <= rq42(m8_s3);
			px_s4 <= px_s3; py_s4 <= py_s3; pz_s4 <= pz_s3;

			for (int k = 0; k < 9; k++) begin
				m_s5[k] <= m_s4[k];
				m_s6[k] <= m_s5[k];
			end
			for (int j = 0; j < 3; j++) begin
				p_s5[j]   <= 48'(m_s4[j])   * 48'(px_s4);
				p_s5[j+3] <= 48'(m_s4[j+3]) * 48'(py_s4);
				p_s5[j+6] <= 48'(m_s4[j+6]) * 48'(pz_s4);
				t_s6[j]   <= -(50'(p_s5[j]) + 50'(p_s5[j+3]) + 50'(p_s5[j+6]));
			end

			for (int k = 0; k < 9; k++) out_s7[16*k +: 16] <= m_s6[k];
			for (int j = 0; j < 3; j++) out_s7[144 + 32*j +: 32] <= sat32(t_s6[j]);
		end
	end

	assign m_axis_tdata = out_s7;
endmodule
`default_nettype wire

@@ bench/evm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evm_checker: view matrix scoreboard
// Watches both stream channels, predicts each matrix from the accepted pose
// and compares every field of the output transfer in order.
// ----------------------------------------------------------------------------
module evm_checker
	import evm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [143:0] s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [239:0] m_axis_tdata,
	output int                errors,
	output int                pending
);
	logic [239:0] matrix_q[$];
	int           mism = 0;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clampv(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void angle_trig(input logic [15:0] ang, output longint sv,
			output longint cv);
		logic [15:0] a;
		logic flip;
		longint x, y, z, dx, dy;
		a = ang;
		flip = (a >= 16'h4000) && (a < 16'hC000);
		if (flip) begin
			a = a + 16'h8000;
		end
		x = 652032874;
		y = 0;
		z = longint'($signed(a)) * 65536;
		for (int i = 0; i < STEPS; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(atan_at(i));
			end else begin
				x += dx; y -= dy; z += longint'(atan_at(i));
			end
		end
		sv = clampv(fshift(y + 32768, 16), -16384, 16384);
		cv = clampv(fshift(x + 32768, 16), -16384, 16384);
		if (flip) begin
			sv = -sv; cv = -cv;
		end
	endfunction

	function automatic longint rnd42(longint v);
		return clampv(fshift(v + (longint'(1) << 27), 28), -16384, 16384);
	endfunction

	function automatic logic [31:0] xlate(longint a, longint b, longint c,
			longint px, longint py, longint pz);
		longint s;
		s = -(a * px + b * py + c * pz);
		return 32'(clampv(fshift(s + 8192, 14), -64'sd2147483648, 64'sd2147483647));
	endfunction

	function automatic logic [239:0] view_matrix(logic [143:0] d);
		longint sx, cx, sy, cy, sz, cz, px, py, pz;
		longint m[9];
		logic [239:0] r;
		longint q;
		q = 16384;
		angle_trig(d[15:0], sx, cx);
		angle_trig(d[31:16], sy, cy);
		angle_trig(d[47:32], sz, cz);
		px = longint'($signed(d[79:48]));
		py = longint'($signed(d[111:80]));
		pz = longint'($signed(d[143:112]));
		m[0] = rnd42(cy * cz * q + sy * sz * sx);
		m[1] = rnd42(sy * cz * sx - cy * sz * q);
		m[2] = rnd42(cx * sy * q);
		m[3] = rnd42(cx * sz * q);
		m[4] = rnd42(cx * cz * q);
		m[5] = -sx;
		m[6] = rnd42(cy * sz * sx - sy * cz * q);
		m[7] = rnd42(cy * cz * sx + sy * sz * q);
		m[8] = rnd42(cy * cx * q);
		for (int k = 0; k < 9; k++) r[k*16 +: 16] = 16'(m[k]);
		r[175:144] = xlate(m[0], m[3], m[6], px, py, pz);
		r[207:176] = xlate(m[1], m[4], m[7], px, py, pz);
		r[239:208] = xlate(m[2], m[5], m[8], px, py, pz);
		return r;
	endfunction

	localparam string FNAME[12] = '{"r00", "r01", "r02", "r10", "r11", "r12",
		"r20", "r21", "r22", "tx", "ty", "tz"};

	assign errors  = mism;
	assign pending = matrix_q.size();

	always @(posedge clk) begin
		logic [239:0] want;
		if (s_axis_tvalid && s_axis_tready) begin
			matrix_q.push_back(view_matrix(s_axis_tdata));
		end
		if (m_axis_tvalid && m_axis_tready) begin
			if (matrix_q.size() == 0) begin
				$error("unexpected output transfer %h", m_axis_tdata);
				mism++;
			end else begin
				want = matrix_q.pop_front();
				for (int k = 0; k < 9; k++)
					if (want[k*16 +: 16] !== m_axis_tdata[k*16 +: 16]) begin
						$error("%s: expected %0d actual %0d", FNAME[k],
							$signed(want[k*16 +: 16]), $signed(m_axis_tdata[k*16 +: 16]));
						mism++;
					end
				for (int k = 0; k < 3; k++)
					if (want[144+k*32 +: 32] !== m_axis_tdata[144+k*32 +: 32]) begin
						$error("%s: expected %0d actual %0d", FNAME[9+k],
							$signed(want[144+k*32 +: 32]),
							$signed(m_axis_tdata[144+k*32 +: 32]));
						mism++;
					end
			end
		end
	end
endmodule
`default_nettype wire

@@ bench/tb_euler_view_matrix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_euler_view_matrix: stream bench for the view matrix block
// Directed poses at the angle quadrant edges and position extremes, then
// random poses, with random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_euler_view_matrix
	import evm_pkg::*;
();

	localparam int LATENCY = STEPS + 7;
	localparam int RANDOM_POSES = 1400;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// pitch, yaw, roll, pos_x, pos_y, pos_z from bit 0 up
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// r00..r22 (16 each), tx, ty, tz (32 each) from bit 0 up
	logic [239:0] m_axis_tdata;
	int           errors;
	int           pending;

	// idle control for the two sides
	bit           calm;        // no idling at all while set
	bit           hold_out;    // long receiver hold-off

	euler_view_matrix dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	evm_checker chk (
		.clk          (clk),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random ready at the falling edge, forced low during hold-off
	initial begin
		m_axis_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) m_axis_tready <= 1'b0;
			else if (calm) m_axis_tready <= 1'b1;
			else m_axis_tready <= ($urandom_range(99) >= 34);
		end
	end

	// corner-heavy position value
	function automatic logic [31:0] pick_pos();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3: return 32'($signed($urandom_range(131072)) - 65536);
			default: return $urandom;
		endcase
	endfunction

	// angle near a quadrant edge or fully random
	function automatic logic [15:0] pick_angle();
		logic [15:0] e;
		if ($urandom_range(3) == 0) begin
			e = 16'($urandom_range(3)) << 14;
			return e + 16'($signed($urandom_range(8)) - 4);
		end
		return 16'($urandom);
	endfunction

	// one pose transfer; optional random idle first, valid stays up afterwards
	task automatic send_pose(input logic [15:0] p, y, r, input logic [31:0] x, yy, z);
		if (!calm) begin
			while ($urandom_range(99) < 34) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {z, yy, x, r, y, p};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [15:0] edges[8];
		edges = '{16'h0000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'hBFFF,
			16'hC000, 16'hFFFF};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		calm          = 1'b0;
		hold_out      = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: half-turn fold boundaries on each angle, extreme positions
		for (int i = 0; i < 8; i++)
			send_pose(edges[i], edges[7-i], edges[(i+3)%8],
				32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
		send_pose(16'h0, 16'h0, 16'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
		for (int i = 0; i < 8; i++)
			send_pose(edges[(i+5)%8], edges[i], edges[(i+1)%8],
				32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF);
		// sender pauses until everything is out
		drain();

		// random poses; a calm stretch, and a long output hold-off mid-way
		for (int n = 0; n < RANDOM_POSES; n++) begin
			calm = (n >= 300 && n < 500);
			if (n == 700) begin
				fork
					begin
						hold_out = 1'b1;
						repeat (3 * LATENCY + 40) @(negedge clk);
						hold_out = 1'b0;
					end
				join_none
			end
			if (n == 1000) drain();
			send_pose(pick_angle(), pick_angle(), pick_angle(),
				pick_pos(), pick_pos(), pick_pos());
		end
		calm = 1'b0;
		drain();
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
`default_nettype wire

@@ files.f @@
rtl/evm_pkg.sv
rtl/evm_cell.sv
rtl/euler_view_matrix.sv
bench/evm_checker.sv
bench/tb_euler_view_matrix.sv
